FILE: rtl/complex_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex arithmetic unit
// Shared forms for concurrent checks on a clocked, reset-qualified block.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// expression never true
`define CAU_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

FILE: rtl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Types, codes and fixed widths shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int OPW        = 16;            // operand part width
   localparam int OUT_FRAC   = 16;            // result fraction bits
   localparam int RESW       = 32;            // result part width
   localparam int QW         = 32;            // quotient bits computed
   localparam int MW         = 2 * OPW + 1;   // magnitude width
   localparam int XW         = ((MW > QW + 1) ? MW : QW + 1) + OUT_FRAC;
   localparam int DIV_STEPS  = 2;             // quotient bits per stage
   localparam int DIV_STAGES = QW / DIV_STEPS;
   localparam int LATENCY    = 4 + DIV_STAGES + 2;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [OPW-1:0]   a_re;
      logic signed [OPW-1:0]   a_im;
      logic signed [OPW-1:0]   b_re;
      logic signed [OPW-1:0]   b_im;
   } req_type;

   typedef struct packed {
      logic signed [RESW-1:0]  res_re;
      logic signed [RESW-1:0]  res_im;
      logic [1:0]              status;
   } rsp_type;

   // item as it moves through the divider stages
   typedef struct packed {
      logic            vld;
      logic [1:0]      op;
      logic            neg_re;
      logic            neg_im;
      logic [MW-1:0]   mag_re;
      logic [MW-1:0]   mag_im;
      logic [MW-1:0]   den;
      logic            ovf_re;
      logic            ovf_im;
      logic [MW-1:0]   rem_re;
      logic [MW-1:0]   rem_im;
      logic [QW-1:0]   q_re;
      logic [QW-1:0]   q_im;
   } pipe_type;

endpackage

FILE: rtl/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Products, sums, magnitudes and divider set-up: four register stages.
// ----------------------------------------------------------------------------
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  cau_pkg::req_type  req,
   output cau_pkg::pipe_type pipe_out
);
   import cau_pkg::*;

   typedef struct packed {
      logic                    vld;
      logic [1:0]              op;
      logic signed [2*OPW-1:0] p_rr;
      logic signed [2*OPW-1:0] p_ii;
      logic signed [2*OPW-1:0] p_ri;
      logic signed [2*OPW-1:0] p_ir;
      logic signed [2*OPW-1:0] p_br;
      logic signed [2*OPW-1:0] p_bi;
      logic signed [OPW:0]     s_re;
      logic signed [OPW:0]     s_im;
   } stg_a_type;

   typedef struct packed {
      logic                 vld;
      logic [1:0]           op;
      logic signed [MW-1:0] v_re;
      logic signed [MW-1:0] v_im;
      logic [MW-1:0]        den;
   } stg_b_type;

   typedef struct packed {
      logic          vld;
      logic [1:0]    op;
      logic          neg_re;
      logic          neg_im;
      logic [MW-1:0] mag_re;
      logic [MW-1:0] mag_im;
      logic [MW-1:0] den;
   } stg_c_type;

   stg_a_type stg_a_in, stg_a_ff;
   stg_b_type stg_b_in, stg_b_ff;
   stg_c_type stg_c_in, stg_c_ff;
   pipe_type  stg_d_in, stg_d_ff;

   // stage A: the six products, and the add/subtract sums
   always_comb begin
      stg_a_in.vld  = take;
      stg_a_in.op   = req.op;
      stg_a_in.p_rr = (2*OPW)'(req.a_re) * (2*OPW)'(req.b_re);
      stg_a_in.p_ii = (2*OPW)'(req.a_im) * (2*OPW)'(req.b_im);
      stg_a_in.p_ri = (2*OPW)'(req.a_re) * (2*OPW)'(req.b_im);
      stg_a_in.p_ir = (2*OPW)'(req.a_im) * (2*OPW)'(req.b_re);
      stg_a_in.p_br = (2*OPW)'(req.b_re) * (2*OPW)'(req.b_re);
      stg_a_in.p_bi = (2*OPW)'(req.b_im) * (2*OPW)'(req.b_im);
      if (req.op == OP_SUB) begin
         stg_a_in.s_re = (OPW+1)'(req.a_re) - (OPW+1)'(req.b_re);
         stg_a_in.s_im = (OPW+1)'(req.a_im) - (OPW+1)'(req.b_im);
      end else begin
         stg_a_in.s_re = (OPW+1)'(req.a_re) + (OPW+1)'(req.b_re);
         stg_a_in.s_im = (OPW+1)'(req.a_im) + (OPW+1)'(req.b_im);
      end
   end

   // stage B: combine products per op
   always_comb begin
      stg_b_in.vld = stg_a_ff.vld;
      stg_b_in.op  = stg_a_ff.op;
      stg_b_in.den = MW'($unsigned(stg_a_ff.p_br)) + MW'($unsigned(stg_a_ff.p_bi));
      unique case (stg_a_ff.op)
         OP_MUL: begin
            stg_b_in.v_re = MW'(stg_a_ff.p_rr) - MW'(stg_a_ff.p_ii);
            stg_b_in.v_im = MW'(stg_a_ff.p_ri) + MW'(stg_a_ff.p_ir);
         end
         OP_DIV: begin
            stg_b_in.v_re = MW'(stg_a_ff.p_rr) + MW'(stg_a_ff.p_ii);
            stg_b_in.v_im = MW'(stg_a_ff.p_ir) - MW'(stg_a_ff.p_ri);
         end
         default: begin
            stg_b_in.v_re = MW'(stg_a_ff.s_re);
            stg_b_in.v_im = MW'(stg_a_ff.s_im);
         end
      endcase
   end

   // stage C: sign and magnitude
   always_comb begin
      stg_c_in.vld    = stg_b_ff.vld;
      stg_c_in.op     = stg_b_ff.op;
      stg_c_in.den    = stg_b_ff.den;
      stg_c_in.neg_re = stg_b_ff.v_re[MW-1];
      stg_c_in.neg_im = stg_b_ff.v_im[MW-1];
      stg_c_in.mag_re = stg_b_ff.v_re[MW-1] ? $unsigned(-stg_b_ff.v_re)
                                            : $unsigned(stg_b_ff.v_re);
      stg_c_in.mag_im = stg_b_ff.v_im[MW-1] ? $unsigned(-stg_b_ff.v_im)
                                            : $unsigned(stg_b_ff.v_im);
   end

   // stage D: quotient overflow test and first partial remainder
   always_comb begin
      stg_d_in.vld    = stg_c_ff.vld;
      stg_d_in.op     = stg_c_ff.op;
      stg_d_in.neg_re = stg_c_ff.neg_re;
      stg_d_in.neg_im = stg_c_ff.neg_im;
      stg_d_in.mag_re = stg_c_ff.mag_re;
      stg_d_in.mag_im = stg_c_ff.mag_im;
      stg_d_in.den    = stg_c_ff.den;
      stg_d_in.ovf_re = {{OUT_FRAC{1'b0}}, stg_c_ff.mag_re} >= {stg_c_ff.den, {OUT_FRAC{1'b0}}};
      stg_d_in.ovf_im = {{OUT_FRAC{1'b0}}, stg_c_ff.mag_im} >= {stg_c_ff.den, {OUT_FRAC{1'b0}}};
      stg_d_in.rem_re = {{OUT_FRAC{1'b0}}, stg_c_ff.mag_re[MW-1:OUT_FRAC]};
      stg_d_in.rem_im = {{OUT_FRAC{1'b0}}, stg_c_ff.mag_im[MW-1:OUT_FRAC]};
      stg_d_in.q_re   = '0;
      stg_d_in.q_im   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_a_ff.vld <= 1'b0;
         stg_b_ff.vld <= 1'b0;
         stg_c_ff.vld <= 1'b0;
         stg_d_ff.vld <= 1'b0;
      end else begin
         stg_a_ff <= stg_a_in;
         stg_b_ff <= stg_b_in;
         stg_c_ff <= stg_c_in;
         stg_d_ff <= stg_d_in;
      end
   end

   assign pipe_out = stg_d_ff;

endmodule

FILE: rtl/cau_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_stage
// One stage of the restoring divider: a few quotient bits for both parts.
// ----------------------------------------------------------------------------
module cau_div_stage #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cau_pkg::pipe_type pipe_in,
   output cau_pkg::pipe_type pipe_out
);
   import cau_pkg::*;

   localparam int QPW = $clog2(QW);
   localparam int MPW = $clog2(MW);

   pipe_type stage_in, stage_ff;

   always_comb begin
      int             idx;
      logic [QPW-1:0] q_pos;
      logic [MPW-1:0] m_pos;
      logic           bit_re;
      logic           bit_im;
      logic [MW-1:0]  t_re;
      logic [MW-1:0]  t_im;
      stage_in = pipe_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
         idx    = QW - 1 - (STAGE * DIV_STEPS + k);
         q_pos  = QPW'(idx);
         m_pos  = MPW'(idx - OUT_FRAC);
         bit_re = 1'b0;
         bit_im = 1'b0;
         if (idx >= OUT_FRAC) begin
            bit_re = pipe_in.mag_re[m_pos];
            bit_im = pipe_in.mag_im[m_pos];
         end
         t_re = {stage_in.rem_re[MW-2:0], bit_re};
         t_im = {stage_in.rem_im[MW-2:0], bit_im};
         if (t_re >= pipe_in.den) begin
            stage_in.rem_re      = t_re - pipe_in.den;
            stage_in.q_re[q_pos] = 1'b1;
         end else begin
            stage_in.rem_re = t_re;
         end
         if (t_im >= pipe_in.den) begin
            stage_in.rem_im      = t_im - pipe_in.den;
            stage_in.q_im[q_pos] = 1'b1;
         end else begin
            stage_in.rem_im = t_im;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign pipe_out = stage_ff;

endmodule

FILE: rtl/cau_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_finish
// Output scaling, saturation, sign and status: two register stages.
// ----------------------------------------------------------------------------
module cau_finish #(
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  cau_pkg::pipe_type pipe_in,
   output logic              rsp_valid,
   output cau_pkg::rsp_type  rsp_item
);
   import cau_pkg::*;

   localparam int RSH_MUL = (2 * FRAC_BITS >= OUT_FRAC) ? 2 * FRAC_BITS - OUT_FRAC : 0;
   localparam int LSH_MUL = (2 * FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - 2 * FRAC_BITS : 0;
   localparam int LSH_ADD = OUT_FRAC - FRAC_BITS;
   localparam logic [XW-1:0] CLIP   = {{(XW-QW-1){1'b0}}, 1'b1, {QW{1'b0}}};
   localparam logic [XW-1:0] LIM_P  = {{(XW-RESW+1){1'b0}}, {(RESW-1){1'b1}}};
   localparam logic [XW-1:0] LIM_N  = LIM_P + XW'(1);

   typedef struct packed {
      logic            vld;
      logic            dz;
      logic            sat;
      logic            neg_re;
      logic            neg_im;
      logic [RESW-1:0] m_re;
      logic [RESW-1:0] m_im;
   } stg_f_type;

   stg_f_type stg_f_in, stg_f_ff;
   logic      vld_in, vld_ff;
   rsp_type   rsp_in, rsp_ff;

   function automatic logic [XW-1:0] scale(input logic [1:0]    op,
                                           input logic [MW-1:0] mag,
                                           input logic          ovf,
                                           input logic [QW-1:0] q);
      logic [XW-1:0] x;
      x = XW'(mag);
      unique case (op)
         OP_DIV: x = ovf ? CLIP : XW'(q);
         OP_MUL: begin
            x = x >> RSH_MUL;
            if (x > CLIP) x = CLIP;
            x = x << LSH_MUL;
         end
         default: begin
            if (x > CLIP) x = CLIP;
            x = x << LSH_ADD;
         end
      endcase
      return x;
   endfunction

   always_comb begin
      logic [XW-1:0] x_re;
      logic [XW-1:0] x_im;
      logic [XW-1:0] l_re;
      logic [XW-1:0] l_im;
      x_re = scale(pipe_in.op, pipe_in.mag_re, pipe_in.ovf_re, pipe_in.q_re);
      x_im = scale(pipe_in.op, pipe_in.mag_im, pipe_in.ovf_im, pipe_in.q_im);
      l_re = pipe_in.neg_re ? LIM_N : LIM_P;
      l_im = pipe_in.neg_im ? LIM_N : LIM_P;
      stg_f_in.vld    = pipe_in.vld;
      stg_f_in.dz     = (pipe_in.op == OP_DIV) && (pipe_in.den == '0);
      stg_f_in.sat    = (x_re > l_re) || (x_im > l_im);
      stg_f_in.neg_re = pipe_in.neg_re;
      stg_f_in.neg_im = pipe_in.neg_im;
      stg_f_in.m_re   = (x_re > l_re) ? l_re[RESW-1:0] : x_re[RESW-1:0];
      stg_f_in.m_im   = (x_im > l_im) ? l_im[RESW-1:0] : x_im[RESW-1:0];
   end

   always_comb begin
      vld_in = stg_f_ff.vld;
      if (stg_f_ff.dz) begin
         rsp_in.res_re = '0;
         rsp_in.res_im = '0;
         rsp_in.status = ST_DIV0;
      end else begin
         rsp_in.res_re = stg_f_ff.neg_re ? -stg_f_ff.m_re : stg_f_ff.m_re;
         rsp_in.res_im = stg_f_ff.neg_im ? -stg_f_ff.m_im : stg_f_ff.m_im;
         rsp_in.status = stg_f_ff.sat ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_f_ff.vld <= 1'b0;
         vld_ff       <= 1'b0;
      end else begin
         stg_f_ff <= stg_f_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; busy is never raised and results cannot stall.
// The pipeline is 4 front stages, 16 divider stages at two quotient bits each, 2 finish.
// Reset (synchronous) clears the valid bits of every stage; items in flight are lost.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on Q8.8 operands, Q16.16 results.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cau_pkg::req_type req_item,
   output logic             rsp_valid,
   output cau_pkg::rsp_type rsp_item
);
   import cau_pkg::*;

   // every op runs through the same chain so results leave in order
   pipe_type front_out;
   pipe_type div_chain [DIV_STAGES+1];

   // no back-pressure: an item may enter on every cycle
   assign busy = 1'b0;

   // front end: products, sums, magnitudes, divider set-up
   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (start && !busy),
      .req      (req_item),
      .pipe_out (front_out)
   );

   assign div_chain[0] = front_out;

   // divider: num * 2^16 / den, two quotient bits per stage; other ops
   // simply ride along in the same stages
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      cau_div_stage #(.STAGE(s)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .pipe_in  (div_chain[s]),
         .pipe_out (div_chain[s+1])
      );
   end

   // scaling to Q16.16, saturation and status
   cau_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
      .clock     (clock),
      .reset     (reset),
      .pipe_in   (div_chain[DIV_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: rtl/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

module cau_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input cau_pkg::req_type req_item,
   input logic             rsp_valid,
   input cau_pkg::rsp_type rsp_item
);
   import cau_pkg::*;

   `CAU_ASSERT_NEVER(a_no_busy, clock, reset, busy, "busy raised")
   `CAU_ASSERT_IMP(a_rsp_has_item, clock, reset, rsp_valid, $past(start && !busy, LATENCY), "result without item")
   `CAU_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_item.status != 2'd3, "bad status")
   `CAU_ASSERT_IMP(a_div0_zero, clock, reset, rsp_valid && rsp_item.status == ST_DIV0, rsp_item.res_re == '0 && rsp_item.res_im == '0, "div0 not zero")
   `CAU_ASSERT_IMP(a_sat_value, clock, reset, rsp_valid && rsp_item.status == ST_SAT, rsp_item.res_re == 32'h7FFFFFFF || rsp_item.res_re == 32'h80000000 || rsp_item.res_im == 32'h7FFFFFFF || rsp_item.res_im == 32'h80000000, "sat without limit")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for complex_arithmetic_unit: directed corner items, then
// random ones, with random gaps on the sender side and one full drain pause.
// Every result is compared field by field against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
   import cau_pkg::*;

   localparam int N_RANDOM  = 730;
   localparam int MAX_GAP   = 12;
   localparam int CYCLE_CAP = 200000;
   localparam int TAIL      = 40;    // comfortably past the LATENCY of the unit

   typedef struct {
      req_type item;
      int      gap;      // idle cycles before the item is offered
      bit      drain;    // hold off until every result is back
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   pending_type pending_q[$];
   rsp_type     expected_q[$];
   bit          took;          // item accepted at the last rising edge
   int          gap_left;
   int          errors;
   int          n_results;
   int          op_count[4];
   int          n_div0, n_sat;
   int          cycles;

   complex_arithmetic_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // --- predictor -----------------------------------------------------------

   // saturate a signed magnitude to a Q16.16 pattern
   function automatic logic [31:0] clamp_q16(bit neg, logic [63:0] mag, ref bit sat);
      logic [63:0] lim;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (mag > lim) begin
         mag = lim;
         sat = 1'b1;
      end
      return neg ? 32'(-mag) : mag[31:0];
   endfunction

   // truncated |num| * 2^16 / den, clipped once the integer part reaches 2^16
   function automatic logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
      if (num / den >= 64'd65536) return 64'h1_0000_0000;
      return (num << 16) / den;
   endfunction

   function automatic logic [63:0] abs64(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic rsp_type complex_result(req_type r);
      rsp_type     o;
      longint      ar, ai, br, bi, sr, si;
      logic [63:0] mr, mi, den;
      bit          sat;
      ar  = r.a_re;
      ai  = r.a_im;
      br  = r.b_re;
      bi  = r.b_im;
      sat = 1'b0;
      o   = '0;
      case (r.op)
         OP_ADD, OP_SUB: begin
            if (r.op == OP_SUB) begin
               br = -br;
               bi = -bi;
            end
            sr = ar + br;
            si = ai + bi;
            mr = abs64(sr) << 8;     // Q8.8 to Q16.16
            mi = abs64(si) << 8;
         end
         OP_MUL: begin
            sr = ar * br - ai * bi;
            si = ar * bi + ai * br;
            mr = abs64(sr);          // Q16.16 already
            mi = abs64(si);
         end
         default: begin
            den = 64'(br * br + bi * bi);
            if (den == 0) begin
               o.status = ST_DIV0;
               return o;
            end
            sr = ar * br + ai * bi;
            si = ai * br - ar * bi;
            mr = scaled_quotient(abs64(sr), den);
            mi = scaled_quotient(abs64(si), den);
         end
      endcase
      o.res_re = clamp_q16(sr < 0, mr, sat);
      o.res_im = clamp_q16(si < 0, mi, sat);
      o.status = sat ? ST_SAT : ST_OK;
      return o;
   endfunction

   // --- stimulus helpers ----------------------------------------------------

   function automatic logic [15:0] random_part();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'($urandom_range(0, 512)) - 16'd256;  // small, near zero
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_item(logic [1:0] op, logic [15:0] ar, logic [15:0] ai,
                             logic [15:0] br, logic [15:0] bi, int gap, bit drain);
      pending_type p;
      p.item  = '{op: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
      p.gap   = gap;
      p.drain = drain;
      pending_q = {pending_q, p};
   endtask

   // --- driver: changes inputs on the falling edge --------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !took) begin
            // offered item not yet taken: hold it
         end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_q.size() > 0 && pending_q[0].drain && expected_q.size() > 0) begin
            start <= 1'b0;     // wait for every result before going on
         end else if (pending_q.size() > 0) begin
            pending_type p;
            p = pending_q.pop_front();
            if (p.gap > 0) begin
               start    <= 1'b0;
               gap_left <= p.gap - 1;
               p.gap    = 0;
               pending_q.push_front(p);
            end else begin
               req_item <= p.item;
               start    <= 1'b1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // --- monitor: samples on the rising edge ---------------------------------
   always @(posedge clock) begin
      took = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            took = 1'b1;
            expected_q = {expected_q, complex_result(req_item)};
            op_count[req_item.op]++;
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $error("result with nothing expected: re %h im %h status %0d",
                      rsp_item.res_re, rsp_item.res_im, rsp_item.status);
               errors++;
            end else begin
               rsp_type e;
               e = expected_q.pop_front();
               n_results++;
               if (e.status == ST_DIV0) n_div0++;
               if (e.status == ST_SAT)  n_sat++;
               if (rsp_item.res_re !== e.res_re) begin
                  $error("res_re: expected %h, got %h", e.res_re, rsp_item.res_re);
                  errors++;
               end
               if (rsp_item.res_im !== e.res_im) begin
                  $error("res_im: expected %h, got %h", e.res_im, rsp_item.res_im);
                  errors++;
               end
               if (rsp_item.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_item.status);
                  errors++;
               end
            end
         end
      end
   end

   // --- watchdog ------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout with %0d results outstanding", expected_q.size());
         $display("complex_arithmetic_unit regression: fail");
         $finish;
      end
   end

   // --- sequence ------------------------------------------------------------
   initial begin
      int mode;
      errors    = 0;
      n_results = 0;
      n_div0    = 0;
      n_sat     = 0;
      gap_left  = 0;
      cycles    = 0;
      took      = 1'b0;

      // directed corners: every op at the range ends, and with a zero second operand
      for (int op = 0; op < 4; op++) begin
         queue_item(op[1:0], 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0);
         queue_item(op[1:0], 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0);
         queue_item(op[1:0], 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1, 0);
         queue_item(op[1:0], 16'h0100, 16'hFF00, 16'h0000, 16'h0000, 0, 0);
      end
      // multiply at the range ends, divide by zero, tiny and huge quotients, then a subtract
      queue_item(OP_MUL, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 0, 0);
      queue_item(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 0, 0);
      queue_item(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2, 0);
      queue_item(OP_DIV, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 0, 0);
      queue_item(OP_DIV, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000, 0, 0);
      queue_item(OP_DIV, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 0, 0);
      queue_item(OP_DIV, 16'h0300, 16'h0400, 16'h0300, 16'hFC00, 0, 0);
      queue_item(OP_SUB, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 0, 0);

      // random part: bursts with no gaps, and bursts with random gaps
      mode = 0;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 40 == 0) mode = $urandom_range(0, 2);
         queue_item(2'($urandom), random_part(), random_part(), random_part(),
                    random_part(), mode == 0 ? 0 : $urandom_range(0, MAX_GAP),
                    i == N_RANDOM / 2);
      end

      repeat (5) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      wait (pending_q.size() == 0 && !start && expected_q.size() == 0);
      repeat (TAIL) @(posedge clock);

      $display("covered %0d results: add %0d, sub %0d, mul %0d, div %0d",
               n_results, op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("divide-by-zero results %0d, saturated results %0d", n_div0, n_sat);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("complex_arithmetic_unit regression: pass");
      end else begin
         $display("complex_arithmetic_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_stage.sv
rtl/cau_finish.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
tb/tb_top.sv
